>>> sv/isc_pkg.sv
// Shared constants of the intercept time solver: outcome codes and result widths.
`default_nettype none

package isc_pkg;

    localparam int OUTCOME_WIDTH = 2;
    localparam int TIME_WIDTH    = 24;
    localparam int TIME_FRAC     = 8;

    localparam logic [OUTCOME_WIDTH-1:0] OUTCOME_HERE = 2'd0;
    localparam logic [OUTCOME_WIDTH-1:0] OUTCOME_HIT  = 2'd1;
    localparam logic [OUTCOME_WIDTH-1:0] OUTCOME_NONE = 2'd2;

    localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

endpackage

`default_nettype wire

>>> sv/intercept_time_solver.sv
// Intercept time solver: pipelined quadratic solve with square root and divide pipelines.
//
//  channel   | dir | word fields (lowest bit first)
//  s_axis    | in  | pursuer_x, pursuer_y, pursuer_speed, target_x, target_y,
//            |     | target_vel_x, target_vel_y
//  m_axis    | out | outcome, meet_time
//
// One word enters every cycle while the output is not stalled; RW is the root width
// of the square root pipeline (31 at the default widths), and the divide pipeline
// yields a 25-bit quotient.
// rst_n clears every valid bit, including the input skid's; data registers are not reset.
// A stalled output freezes the whole pipeline; one more word is held in the input skid.
`default_nettype none

module intercept_time_solver #(
    parameter int COORD_WIDTH     = 13,
    parameter int SPEED_FRAC_BITS = 12
) (
    input  wire logic clk,
    input  wire logic rst_n,
    // pursuer_x, pursuer_y, pursuer_speed, target_x, target_y, target_vel_x, target_vel_y
    input  wire logic [((4*COORD_WIDTH+55)/8)*8-1:0] s_tdata,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // outcome, meet_time
    output logic [31:0] m_tdata,
    output logic        m_tvalid,
    input  wire logic   m_tready
);
    import isc_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int F     = SPEED_FRAC_BITS;
    localparam int INW   = ((4*CW+55)/8)*8;
    localparam int DW    = CW + 1;
    localparam int D2W   = 2*CW + 1;
    localparam int PW    = CW + 17;
    localparam int QBW   = CW + 18;
    localparam int BW    = CW + 17;
    localparam int QAW   = 34;
    localparam int AW    = 33;
    localparam int BSQW  = 2*BW;
    localparam int ADW   = AW + D2W;
    localparam int EW0   = ((BSQW > ADW) ? BSQW : ADW) + 1;
    localparam int EW    = EW0 + (EW0 % 2);
    localparam int RW    = EW / 2;
    localparam int RBW   = ((RW > BW) ? RW : BW) + 1;
    localparam int NUMW  = (D2W > RBW) ? D2W : RBW;
    localparam int DENW0 = (RBW > AW) ? RBW : AW;
    localparam int DENW  = (DENW0 > BW + 1) ? DENW0 : BW + 1;
    localparam int SH    = F + TIME_FRAC;
    localparam int NW    = NUMW + SH;
    localparam int QW    = TIME_WIDTH + 1;
    localparam int CMPW  = ((NW > DENW + QW) ? NW : DENW + QW) + 1;
    localparam longint NZ_LIM = ((64'd1 << (2*F)) + 64'd999999) / 64'd1000000;

    typedef struct packed {
        logic           here;
        logic           nz;
        logic           negdisc;
        logic           qa_pos;
        logic           qb_pos;
        logic [D2W-1:0] d2;
        logic [AW-1:0]  absa;
        logic [BW-1:0]  absb;
    } ctx_t;

    // ---------------- input skid and pipeline enable ----------------
    logic           skid_valid_reg;
    logic [INW-1:0] skid_reg;
    logic           out_valid_reg;
    logic           en;
    logic           in_valid;
    logic [INW-1:0] in_word;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = !skid_valid_reg;
    assign in_valid = skid_valid_reg || s_tvalid;
    assign in_word  = skid_valid_reg ? skid_reg : s_tdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!en && s_tvalid && s_tready)
        begin
            skid_reg <= s_tdata;
        end
    end

    // ---------------- front stages ----------------
    logic [CW-1:0] px, py, tx, ty;
    logic [15:0]   spd;
    logic [15:0]   vxi, vyi;
    assign px  = in_word[CW-1:0];
    assign py  = in_word[2*CW-1:CW];
    assign spd = in_word[2*CW+15:2*CW];
    assign tx  = in_word[3*CW+15:2*CW+16];
    assign ty  = in_word[4*CW+15:3*CW+16];
    assign vxi = in_word[4*CW+31:4*CW+16];
    assign vyi = in_word[4*CW+47:4*CW+32];

    logic [4:0] fv_reg;

    logic signed [DW-1:0] dx_reg, dy_reg;
    logic [15:0]          s_reg;
    logic signed [15:0]   vx_reg, vy_reg;

    logic [2*CW-1:0]      dxsq_reg, dysq_reg;
    logic [31:0]          ssq_reg;
    logic [30:0]          vxsq_reg, vysq_reg;
    logic signed [PW-1:0] pbx_reg, pby_reg;

    logic [D2W-1:0]        d2_reg;
    logic signed [QAW-1:0] qa_reg;
    logic signed [QBW-1:0] qb_reg;

    ctx_t           c4_reg;
    logic           qa_neg4_reg;
    ctx_t           c5_reg;
    logic           qa_neg5_reg;
    logic [BSQW-1:0] bsq_reg;
    logic [ADW-1:0]  ad_reg;

    logic signed [QAW-1:0] absa_next;
    logic signed [QBW-1:0] absb_next;
    logic [EW:0]           ediff_next;
    logic [EW-1:0]         esum_next;
    ctx_t                  ctx5_next;

    assign absa_next  = qa_reg[QAW-1] ? -qa_reg : qa_reg;
    assign absb_next  = qb_reg[QBW-1] ? -qb_reg : qb_reg;
    assign ediff_next = (EW+1)'(bsq_reg) - (EW+1)'(ad_reg);
    assign esum_next  = EW'(bsq_reg) + EW'(ad_reg);

    // borrow marks a negative quarter discriminant
    always_comb
    begin
        ctx5_next         = c5_reg;
        ctx5_next.negdisc = qa_neg5_reg && ediff_next[EW];
    end

    // square root pipeline arrays, index 0 is the discriminant stage
    logic [RW:0]   sq_v_reg;
    logic [EW-1:0] sq_e_reg    [0:RW];
    logic [RW-1:0] sq_root_reg [0:RW];
    logic [RW:0]   sq_rem_reg  [0:RW];
    ctx_t          sq_ctx_reg  [0:RW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg      <= '0;
            sq_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            fv_reg      <= {fv_reg[3:0], in_valid};
            sq_v_reg[0] <= fv_reg[4];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // differences and raw inputs
            dx_reg <= $signed({1'b0, tx}) - $signed({1'b0, px});
            dy_reg <= $signed({1'b0, ty}) - $signed({1'b0, py});
            s_reg  <= spd;
            vx_reg <= $signed(vxi);
            vy_reg <= $signed(vyi);
            // products
            dxsq_reg <= (2*CW)'(dx_reg * dx_reg);
            dysq_reg <= (2*CW)'(dy_reg * dy_reg);
            ssq_reg  <= s_reg * s_reg;
            vxsq_reg <= 31'(vx_reg * vx_reg);
            vysq_reg <= 31'(vy_reg * vy_reg);
            pbx_reg  <= PW'(dx_reg * vx_reg);
            pby_reg  <= PW'(dy_reg * vy_reg);
            // coefficients
            d2_reg <= D2W'(dxsq_reg) + D2W'(dysq_reg);
            qa_reg <= $signed({2'b00, ssq_reg}) - $signed({3'b000, vxsq_reg})
                      - $signed({3'b000, vysq_reg});
            qb_reg <= $signed({pbx_reg[PW-1], pbx_reg}) + $signed({pby_reg[PW-1], pby_reg});
            // magnitudes and flags
            c4_reg.here    <= (d2_reg <= D2W'(1));
            c4_reg.nz      <= (AW'(absa_next) < AW'(NZ_LIM));
            c4_reg.negdisc <= 1'b0;
            c4_reg.qa_pos  <= !qa_reg[QAW-1] && (qa_reg != '0);
            c4_reg.qb_pos  <= !qb_reg[QBW-1] && (qb_reg != '0);
            c4_reg.d2      <= d2_reg;
            c4_reg.absa    <= AW'(absa_next);
            c4_reg.absb    <= BW'(absb_next);
            qa_neg4_reg    <= qa_reg[QAW-1];
            // squared terms
            c5_reg      <= c4_reg;
            qa_neg5_reg <= qa_neg4_reg;
            bsq_reg     <= c4_reg.absb * c4_reg.absb;
            ad_reg      <= c4_reg.absa * c4_reg.d2;
            // quarter discriminant
            sq_ctx_reg[0]  <= ctx5_next;
            sq_e_reg[0]    <= qa_neg5_reg ? ediff_next[EW-1:0] : esum_next;
            sq_root_reg[0] <= '0;
            sq_rem_reg[0]  <= '0;
        end
    end

    // ---------------- square root, one root bit per stage ----------------
    genvar j;
    generate
        for (j = 0; j < RW; j++)
        begin : g_sqrt
            localparam int K = RW - 1 - j;
            logic [RW+2:0] shifted;
            logic [RW+2:0] trial;
            logic          take;
            assign shifted = {sq_rem_reg[j], sq_e_reg[j][2*K+1 -: 2]};
            assign trial   = {1'b0, sq_root_reg[j], 2'b01};
            assign take    = (shifted >= trial);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sq_v_reg[j+1] <= 1'b0;
                end
                else if (en)
                begin
                    sq_v_reg[j+1] <= sq_v_reg[j];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sq_e_reg[j+1]    <= sq_e_reg[j];
                    sq_ctx_reg[j+1]  <= sq_ctx_reg[j];
                    sq_rem_reg[j+1]  <= take ? (RW+1)'(shifted - trial) : (RW+1)'(shifted);
                    sq_root_reg[j+1] <= {sq_root_reg[j][RW-2:0], take};
                end
            end
        end
    endgenerate

    // ---------------- case selection ----------------
    ctx_t            cs;
    logic [RW-1:0]   root;
    logic [OUTCOME_WIDTH-1:0] oc_next;
    logic [NUMW-1:0] num_next;
    logic [DENW-1:0] den_next;

    assign cs   = sq_ctx_reg[RW];
    assign root = sq_root_reg[RW];

    always_comb
    begin
        oc_next  = OUTCOME_NONE;
        num_next = '0;
        den_next = DENW'(1);
        if (cs.here)
        begin
            oc_next = OUTCOME_HERE;
        end
        else if (cs.negdisc)
        begin
            oc_next = OUTCOME_NONE;
        end
        else if (cs.nz)
        begin
            if (cs.qb_pos)
            begin
                oc_next  = OUTCOME_HIT;
                num_next = NUMW'(cs.d2);
                den_next = DENW'({cs.absb, 1'b0});
            end
        end
        else if (cs.qb_pos)
        begin
            oc_next  = OUTCOME_HIT;
            num_next = NUMW'(cs.d2);
            den_next = DENW'(RBW'(cs.absb) + RBW'(root));
        end
        else if (cs.qa_pos)
        begin
            oc_next  = OUTCOME_HIT;
            num_next = NUMW'(RBW'(cs.absb) + RBW'(root));
            den_next = DENW'(cs.absa);
        end
    end

    logic                     sel_v_reg;
    logic [OUTCOME_WIDTH-1:0] sel_oc_reg;
    logic [NUMW-1:0]          sel_num_reg;
    logic [DENW-1:0]          sel_den_reg;

    logic [NW-1:0]            nsh;
    assign nsh = {sel_num_reg, {SH{1'b0}}};

    // divide pipeline arrays, index 0 is the overflow check stage
    logic [QW:0]              dv_v_reg;
    logic [OUTCOME_WIDTH-1:0] dv_oc_reg  [0:QW];
    logic                     dv_ovf_reg [0:QW];
    logic [NW-1:0]            dv_rem_reg [0:QW];
    logic [DENW-1:0]          dv_den_reg [0:QW];
    logic [QW-1:0]            dv_q_reg   [0:QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_v_reg   <= 1'b0;
            dv_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            sel_v_reg   <= sq_v_reg[RW];
            dv_v_reg[0] <= sel_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sel_oc_reg    <= oc_next;
            sel_num_reg   <= num_next;
            sel_den_reg   <= den_next;
            dv_oc_reg[0]  <= sel_oc_reg;
            dv_ovf_reg[0] <= (CMPW'(nsh) >= (CMPW'(sel_den_reg) << QW));
            dv_rem_reg[0] <= nsh;
            dv_den_reg[0] <= sel_den_reg;
            dv_q_reg[0]   <= '0;
        end
    end

    // ---------------- restoring divide, one quotient bit per stage ----------------
    genvar i;
    generate
        for (i = 0; i < QW; i++)
        begin : g_div
            localparam int B = QW - 1 - i;
            logic [CMPW-1:0] dsh;
            logic            take;
            assign dsh  = CMPW'(dv_den_reg[i]) << B;
            assign take = (CMPW'(dv_rem_reg[i]) >= dsh);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dv_v_reg[i+1] <= 1'b0;
                end
                else if (en)
                begin
                    dv_v_reg[i+1] <= dv_v_reg[i];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dv_oc_reg[i+1]  <= dv_oc_reg[i];
                    dv_ovf_reg[i+1] <= dv_ovf_reg[i];
                    dv_den_reg[i+1] <= dv_den_reg[i];
                    dv_rem_reg[i+1] <= take ? dv_rem_reg[i] - NW'(dsh) : dv_rem_reg[i];
                    dv_q_reg[i+1]   <= {dv_q_reg[i][QW-2:0], take};
                end
            end
        end
    endgenerate

    // ---------------- output register ----------------
    logic [OUTCOME_WIDTH-1:0] out_oc_reg;
    logic [TIME_WIDTH-1:0]    out_time_reg;
    logic [TIME_WIDTH-1:0]    time_next;

    always_comb
    begin
        if (dv_oc_reg[QW] != OUTCOME_HIT)
        begin
            time_next = '0;
        end
        else if (dv_ovf_reg[QW] || dv_q_reg[QW][QW-1])
        begin
            time_next = TIME_MAX;
        end
        else
        begin
            time_next = dv_q_reg[QW][TIME_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_v_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_oc_reg   <= dv_oc_reg[QW];
            out_time_reg <= time_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_time_reg, out_oc_reg};

    // ---------------- assertions ----------------
    a_time_only_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[1:0] != OUTCOME_HIT)) |-> (m_tdata[25:2] == '0))
        else $error("meet_time non-zero without an intercept");

    a_skid_catches: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !en) |=> skid_valid_reg)
        else $error("word accepted during stall not held in skid");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && en) |=> !skid_valid_reg)
        else $error("skid word not drained when pipeline advanced");

endmodule

`default_nettype wire
